// ===== rtl/tmb_pkg.sv =====
// tmb_pkg: shared constants, types and state encodings for the temporal median background block
// no dependencies; used by every other file of the block except tmb_ram
package tmb_pkg;

    localparam int PIXELS      = 64;
    localparam int WINDOW      = 31;
    localparam int QUEUE_DEPTH = 2;

    localparam int IDX_W     = 6;
    localparam int SAMPLE_W  = 8;
    localparam int SLOT_W    = $clog2(WINDOW);
    localparam int CNT_W     = $clog2(WINDOW + 1);
    localparam int PIX_W     = $clog2(PIXELS);
    localparam int HADDR_W   = $clog2(PIXELS * WINDOW);
    localparam int HDEPTH    = PIXELS * WINDOW;
    localparam int QPTR_W    = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W    = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [CNT_W-1:0]  fill;
        logic [SLOT_W-1:0] oldest;
    } t_meta;

    localparam int META_W = $bits(t_meta);

    typedef struct packed {
        logic [IDX_W-1:0]    pixel;
        logic [SAMPLE_W-1:0] sample;
        logic [SLOT_W-1:0]   slot;
        logic [CNT_W-1:0]    cnt;
    } t_job;

    typedef enum logic {
        F_IDLE,
        F_UPD
    } t_front_state;

    typedef enum logic [1:0] {
        B_IDLE,
        B_LOAD,
        B_OUT
    } t_back_state;

    function automatic logic [HADDR_W-1:0] hist_addr(input logic [IDX_W-1:0] pix,
                                                    input logic [SLOT_W-1:0] slot);
        logic [HADDR_W-1:0] base;
        base = HADDR_W'(pix[PIX_W-1:0]) * HADDR_W'(WINDOW);
        return base + HADDR_W'(slot);
    endfunction

endpackage

// ===== rtl/tmb_in_if.sv =====
// tmb_in_if: valid/ready channel carrying one input sample word
// depends on tmb_pkg
interface tmb_in_if import tmb_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [IDX_W-1:0]    pixel_index;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, output pixel_index, output sample, input ready);
    modport sink   (input valid, input pixel_index, input sample, output ready);
endinterface

// ===== rtl/tmb_out_if.sv =====
// tmb_out_if: valid/ready channel carrying one background/foreground result word
// depends on tmb_pkg
interface tmb_out_if import tmb_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [IDX_W-1:0]    pixel_out;
    logic [SAMPLE_W-1:0] background;
    logic [SAMPLE_W-1:0] foreground;

    modport source (output valid, output pixel_out, output background, output foreground,
                    input ready);
    modport sink   (input valid, input pixel_out, input background, input foreground,
                    output ready);
endinterface

// ===== rtl/tmb_ram.sv =====
// tmb_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module tmb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/tmb_queue.sv =====
// tmb_queue: short job queue between the front and back parts
// depends on tmb_pkg
module tmb_queue import tmb_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_push_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_job o_job
);

    t_job              r_slots [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slots[r_wr] <= i_push_job;
        end
    end

    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_slots[r_rd];

endmodule

// ===== rtl/tmb_front.sv =====
// tmb_front: accepts sample words, updates per-pixel fill count and oldest slot,
// and queues one job per word; depends on tmb_pkg, tmb_in_if and tmb_ram
module tmb_front import tmb_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tmb_in_if.sink     i_in,
    input  logic       i_q_full,
    output logic       o_push,
    output t_job       o_push_job
);

    t_front_state        r_state;
    t_front_state        n_state;
    logic [PIXELS-1:0]   r_meta_vld;
    logic [IDX_W-1:0]    r_pix;
    logic [SAMPLE_W-1:0] r_sample;
    logic                r_hit;
    logic                accept;
    logic                meta_we;
    t_meta               meta_rd;
    t_meta               meta_cur;
    t_meta               meta_new;
    logic [SLOT_W-1:0]   slot;
    logic [CNT_W-1:0]    cnt;
    logic [SLOT_W-1:0]   old_fix;

    tmb_ram #(
        .WIDTH(META_W),
        .DEPTH(PIXELS)
    ) u_meta_ram (
        .i_clk   (i_clk),
        .i_we    (meta_we),
        .i_waddr (r_pix[PIX_W-1:0]),
        .i_wdata (meta_new),
        .i_re    (accept),
        .i_raddr (i_in.pixel_index[PIX_W-1:0]),
        .o_rdata (meta_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_meta_vld <= '0;
        end else if (meta_we) begin
            r_meta_vld[r_pix[PIX_W-1:0]] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pix    <= i_in.pixel_index;
            r_sample <= i_in.sample;
            r_hit    <= r_meta_vld[i_in.pixel_index[PIX_W-1:0]];
        end
    end

    // slot choice: fill in order, then overwrite the oldest entry
    always_comb begin
        meta_cur = r_hit ? meta_rd : '0;
        meta_new = meta_cur;
        old_fix  = (meta_cur.oldest >= SLOT_W'(WINDOW)) ? '0 : meta_cur.oldest;
        if (meta_cur.fill < CNT_W'(WINDOW)) begin
            slot          = SLOT_W'(meta_cur.fill);
            cnt           = meta_cur.fill + 1'b1;
            meta_new.fill = cnt;
        end else begin
            slot            = old_fix;
            cnt             = CNT_W'(WINDOW);
            meta_new.oldest = (old_fix == SLOT_W'(WINDOW - 1)) ? '0 : old_fix + 1'b1;
        end
    end

    always_comb begin
        n_state    = r_state;
        i_in.ready = 1'b0;
        meta_we    = 1'b0;
        o_push     = 1'b0;
        case (r_state)
            F_IDLE: begin
                i_in.ready = !i_q_full;
                if (i_in.valid && !i_q_full) begin
                    n_state = F_UPD;
                end
            end
            F_UPD: begin
                meta_we = 1'b1;
                o_push  = 1'b1;
                n_state = F_IDLE;
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

    assign accept            = i_in.valid && i_in.ready;
    assign o_push_job.pixel  = r_pix;
    assign o_push_job.sample = r_sample;
    assign o_push_job.slot   = slot;
    assign o_push_job.cnt    = cnt;

endmodule

// ===== rtl/tmb_back.sv =====
// tmb_back: writes the sample into the history, streams the history through an
// insertion sorter and presents the median result; depends on tmb_pkg, tmb_out_if, tmb_ram
module tmb_back import tmb_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_empty,
    input  t_job       i_job,
    output logic       o_pop,
    tmb_out_if.source  o_out
);

    t_back_state         r_state;
    t_back_state         n_state;
    t_job                r_job;
    t_job                n_job;
    logic [CNT_W-1:0]    r_issue;
    logic [CNT_W-1:0]    n_issue;
    logic [CNT_W-1:0]    r_fill;
    logic [CNT_W-1:0]    n_fill;
    logic                r_pend;
    logic                n_pend;
    logic [SAMPLE_W-1:0] r_sorted [WINDOW];
    logic [SAMPLE_W-1:0] n_sorted [WINDOW];
    logic [SAMPLE_W-1:0] r_bg;
    logic [SAMPLE_W-1:0] n_bg;
    logic [SAMPLE_W-1:0] r_fg;
    logic [SAMPLE_W-1:0] n_fg;
    logic                hist_we;
    logic [HADDR_W-1:0]  hist_waddr;
    logic                hist_re;
    logic [HADDR_W-1:0]  hist_raddr;
    logic [SAMPLE_W-1:0] hist_rd;
    logic [WINDOW-1:0]   le;
    logic [SAMPLE_W-1:0] mid;

    tmb_ram #(
        .WIDTH(SAMPLE_W),
        .DEPTH(HDEPTH)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (hist_we),
        .i_waddr (hist_waddr),
        .i_wdata (i_job.sample),
        .i_re    (hist_re),
        .i_raddr (hist_raddr),
        .o_rdata (hist_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job    <= n_job;
        r_issue  <= n_issue;
        r_fill   <= n_fill;
        r_sorted <= n_sorted;
        r_bg     <= n_bg;
        r_fg     <= n_fg;
    end

    // entries not above the incoming value form a prefix of the sorted row
    always_comb begin
        for (int k = 0; k < WINDOW; k++) begin
            le[k] = (CNT_W'(k) < r_fill) && (r_sorted[k] <= hist_rd);
        end
    end

    assign mid = r_sorted[SLOT_W'(r_job.cnt >> 1)];

    always_comb begin
        n_state    = r_state;
        n_job      = r_job;
        n_issue    = r_issue;
        n_fill     = r_fill;
        n_pend     = 1'b0;
        n_sorted   = r_sorted;
        n_bg       = r_bg;
        n_fg       = r_fg;
        o_pop      = 1'b0;
        hist_we    = 1'b0;
        hist_waddr = hist_addr(i_job.pixel, i_job.slot);
        hist_re    = 1'b0;
        hist_raddr = hist_addr(r_job.pixel, r_issue[SLOT_W-1:0]);
        o_out.valid = 1'b0;
        case (r_state)
            B_IDLE: begin
                if (!i_q_empty) begin
                    o_pop   = 1'b1;
                    hist_we = 1'b1;
                    n_job   = i_job;
                    n_issue = '0;
                    n_fill  = '0;
                    n_state = B_LOAD;
                end
            end
            B_LOAD: begin
                if (r_issue < r_job.cnt) begin
                    hist_re = 1'b1;
                    n_issue = r_issue + 1'b1;
                    n_pend  = 1'b1;
                end
                if (r_pend) begin
                    n_sorted[0] = le[0] ? r_sorted[0] : hist_rd;
                    for (int k = 1; k < WINDOW; k++) begin
                        if (le[k]) begin
                            n_sorted[k] = r_sorted[k];
                        end else if (le[k-1]) begin
                            n_sorted[k] = hist_rd;
                        end else begin
                            n_sorted[k] = r_sorted[k-1];
                        end
                    end
                    n_fill = r_fill + 1'b1;
                end
                if (!r_pend && r_fill == r_job.cnt) begin
                    n_bg    = mid;
                    n_fg    = (r_job.sample > mid) ? r_job.sample - mid : '0;
                    n_state = B_OUT;
                end
            end
            B_OUT: begin
                o_out.valid = 1'b1;
                if (o_out.ready) begin
                    n_state = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    assign o_out.pixel_out  = r_job.pixel;
    assign o_out.background = r_bg;
    assign o_out.foreground = r_fg;

endmodule

// ===== rtl/temporal_median_background_top.sv =====
// Temporal median background subtraction for a 64-pixel thermal sensor. Each
// word carries a pixel index and an 8-bit sample; the block keeps the last 31
// samples of every pixel and returns the median of that history as background
// and the sample minus it, clamped at zero, as foreground. Histories start empty
// after reset and the median is the upper middle entry while one is filling.
// The front takes a new word only after queueing the last one, into a two-entry
// job queue, and stalls while that queue is full; the back then reads the n
// history entries of the pixel (n at most 31) from the history ram one entry a
// cycle into an insertion sorter. Results leave in input order from an output
// register while the next word is already accepted.
// depends on tmb_pkg, tmb_in_if, tmb_out_if, tmb_front, tmb_queue, tmb_back
module temporal_median_background_top import tmb_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tmb_in_if.sink    i_in,
    tmb_out_if.source o_out
);

    logic q_full;
    logic q_empty;
    logic push;
    logic pop;
    t_job push_job;
    t_job head_job;

    tmb_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_push_job (push_job)
    );

    tmb_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_job (push_job),
        .o_full     (q_full),
        .i_pop      (pop),
        .o_empty    (q_empty),
        .o_job      (head_job)
    );

    tmb_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_job     (head_job),
        .o_pop     (pop),
        .o_out     (o_out)
    );

endmodule

// ===== tb/tb_top.sv =====
// tb_top: self-checking bench for temporal_median_background_top, streaming sample words with
// random gaps and stalls and checking each result against a per-pixel sorted-history median
// depends on tmb_pkg, tmb_in_if, tmb_out_if and temporal_median_background_top
module tb_top;
    import tmb_pkg::*;

    typedef struct {
        logic [IDX_W-1:0]    pixel;
        logic [SAMPLE_W-1:0] sample;
    } t_sample_word;

    typedef struct {
        logic [IDX_W-1:0]    pixel;
        logic [SAMPLE_W-1:0] background;
        logic [SAMPLE_W-1:0] foreground;
    } t_bg_word;

    localparam int N_RANDOM    = 1100;
    localparam int HOLD_AT     = 300;
    localparam int HOLD_CYCLES = 400;
    localparam int QUIET_FROM  = 600;
    localparam int QUIET_TO    = 800;
    localparam int N_HOT       = 4;

    logic i_clk;
    logic i_rst_n;

    tmb_in_if  in_if();
    tmb_out_if out_if();

    temporal_median_background_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_sample_word        pending_words[$];
    t_bg_word            expected_bg[$];
    logic [SAMPLE_W-1:0] history [PIXELS][WINDOW];
    int                  fill_len [PIXELS];
    int                  oldest_pos [PIXELS];
    int                  words_per_pixel [PIXELS];
    int                  n_sent;
    int                  n_checked;
    int                  n_mismatch;
    int                  n_unexpected;
    int                  hold_left;
    logic                hold_done;
    logic                quiet;

    // no random idling on either side inside this window
    assign quiet = (n_sent >= QUIET_FROM) && (n_sent < QUIET_TO);

    function automatic void predict_background(input logic [IDX_W-1:0] pix,
                                               input logic [SAMPLE_W-1:0] smp);
        int                  p;
        int                  n;
        int                  j;
        logic [SAMPLE_W-1:0] key;
        logic [SAMPLE_W-1:0] sorted [WINDOW];
        t_bg_word            res;
        p = int'(pix) % PIXELS;
        if (fill_len[p] < WINDOW) begin
            history[p][fill_len[p]] = smp;
            fill_len[p]++;
        end else begin
            history[p][oldest_pos[p]] = smp;
            oldest_pos[p] = (oldest_pos[p] + 1) % WINDOW;
        end
        n = fill_len[p];
        for (int i = 0; i < n; i++) begin
            key = history[p][i];
            j = i;
            while (j > 0 && sorted[j-1] > key) begin
                sorted[j] = sorted[j-1];
                j--;
            end
            sorted[j] = key;
        end
        res.pixel      = pix;
        res.background = sorted[n / 2];
        res.foreground = (smp > res.background) ? smp - res.background : '0;
        expected_bg.push_back(res);
        words_per_pixel[p]++;
    endfunction

    function automatic void queue_word(input int pix, input int smp);
        t_sample_word w;
        w.pixel  = IDX_W'(pix);
        w.sample = SAMPLE_W'(smp);
        pending_words.push_back(w);
    endfunction

    task automatic wait_for_drain();
        do @(negedge i_clk);
        while (pending_words.size() != 0 || in_if.valid || expected_bg.size() != 0);
    endtask

    initial begin
        i_clk              = 1'b0;
        i_rst_n            = 1'b0;
        in_if.valid        = 1'b0;
        in_if.pixel_index  = '0;
        in_if.sample       = '0;
        out_if.ready       = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin : drive_words
        t_sample_word next_word;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            n_sent      <= 0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                predict_background(in_if.pixel_index, in_if.sample);
                n_sent <= n_sent + 1;
            end
            if (!in_if.valid || in_if.ready) begin
                if (pending_words.size() != 0 && (quiet || $urandom_range(0, 99) >= 9)) begin
                    next_word = pending_words.pop_front();
                    in_if.valid       <= 1'b1;
                    in_if.pixel_index <= next_word.pixel;
                    in_if.sample      <= next_word.sample;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // long output stall while the sender keeps offering words
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && n_sent >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin : check_words
        t_bg_word want;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (expected_bg.size() == 0) begin
                    n_unexpected++;
                    if (n_mismatch + n_unexpected <= 10)
                        $display("unexpected result word: pixel %0d bg %0d fg %0d",
                                 out_if.pixel_out, out_if.background, out_if.foreground);
                end else begin
                    want = expected_bg.pop_front();
                    n_checked++;
                    if (out_if.pixel_out !== want.pixel || out_if.background !== want.background
                            || out_if.foreground !== want.foreground) begin
                        n_mismatch++;
                        if (n_mismatch + n_unexpected <= 10)
                            $display("mismatch: expected pixel %0d bg %0d fg %0d, got pixel %0d bg %0d fg %0d",
                                     want.pixel, want.background, want.foreground,
                                     out_if.pixel_out, out_if.background, out_if.foreground);
                    end
                end
            end
            out_if.ready <= (hold_left == 0) && (quiet || $urandom_range(0, 99) >= 9);
        end
    end

    initial begin
        int hot [N_HOT];
        int level;
        int roll;
        int pix;
        int smp;
        int wrapped;
        int busiest;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // corners: index and sample extremes, fill order, ties, sample below background
        queue_word(0, 255);
        queue_word(63, 0);
        queue_word(0, 0);
        queue_word(0, 128);
        queue_word(63, 255);
        queue_word(63, 255);
        queue_word(42, 170);
        queue_word(21, 85);
        queue_word(42, 85);
        queue_word(21, 170);
        queue_word(0, 1);
        queue_word(0, 254);
        queue_word(63, 128);
        queue_word(63, 127);
        queue_word(7, 200);
        queue_word(7, 200);
        queue_word(7, 200);
        queue_word(7, 100);
        queue_word(56, 0);
        queue_word(56, 255);
        queue_word(56, 0);
        queue_word(56, 255);
        wait_for_drain();

        // a few hot pixels get most words so their histories fill and wrap many times
        for (int k = 0; k < N_HOT; k++)
            hot[k] = $urandom_range(0, PIXELS - 1);
        level = 128;
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == N_RANDOM / 2)
                wait_for_drain();
            roll = $urandom_range(0, 99);
            if (roll < 70)
                pix = hot[$urandom_range(0, N_HOT - 1)];
            else
                pix = $urandom_range(0, PIXELS - 1);
            level = level + int'($urandom_range(0, 2)) - 1;
            if (level < 20)
                level = 20;
            if (level > 235)
                level = 235;
            roll = $urandom_range(0, 99);
            if (roll < 5)
                smp = 0;
            else if (roll < 10)
                smp = 255;
            else if (roll < 45)
                smp = $urandom_range(0, 255);
            else
                smp = level + int'($urandom_range(0, 40)) - 20;
            queue_word(pix, smp);
        end
        wait_for_drain();
        repeat (64) @(posedge i_clk);

        wrapped = 0;
        busiest = 0;
        for (int p = 0; p < PIXELS; p++) begin
            if (words_per_pixel[p] > WINDOW)
                wrapped++;
            if (words_per_pixel[p] > busiest)
                busiest = words_per_pixel[p];
        end
        $display("run: %0d sample words in, %0d results checked, %0d mismatched, %0d unexpected",
                 n_sent, n_checked, n_mismatch, n_unexpected);
        $display("run: %0d pixels wrapped their %0d-deep history, busiest pixel took %0d words",
                 wrapped, WINDOW, busiest);
        if (n_mismatch == 0 && n_unexpected == 0 && expected_bg.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #6000000;
        $display("FAILURE");
        $finish;
    end

endmodule

// ===== temporal_median_background_top.f =====
rtl/tmb_pkg.sv
rtl/tmb_in_if.sv
rtl/tmb_out_if.sv
rtl/tmb_ram.sv
rtl/tmb_queue.sv
rtl/tmb_front.sv
rtl/tmb_back.sv
rtl/temporal_median_background_top.sv
tb/tb_top.sv
